// ----- rtl/core/cts_pkg.sv -----
// Shared types and constants for the cooperative thread scheduler.
package cts_pkg;

	localparam int THREAD_SLOTS_DEF = 8;
	localparam int TICK_BITS_DEF    = 32;

	typedef enum logic [2:0] {
		ST_READY    = 3'd0,
		ST_RUNNING  = 3'd1,
		ST_SLEEPING = 3'd2,
		ST_NOW      = 3'd3,
		ST_WAIT     = 3'd4,
		ST_TIMEDOUT = 3'd5,
		ST_STOPPED  = 3'd6
	} thr_state_t;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_YIELD  = 3'd2,
		CMD_FINISH = 3'd3,
		CMD_NOTIFY = 3'd4,
		CMD_NICE   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EXEC,
		F_CINIT,
		F_SCAN,
		F_FINAL,
		F_NOTIFY,
		F_DONE
	} fsm_t;

	// fixed-width part of one slot row
	typedef struct packed {
		logic       used;
		thr_state_t state;
		logic [7:0] channel;
		logic [15:0] ref_id;
		logic [31:0] tag;
	} slot_row_t;

	// per-field write enables for one row
	typedef struct packed {
		logic used;
		logic state;
		logic wake;
		logic deadline;
		logic channel;
		logic ref_id;
		logic tag;
		logic nice;
	} slot_we_t;

endpackage

// ----- rtl/core/cts_table.sv -----
// Thread slot table: one combinational read port, one masked write port.
module cts_table
	import cts_pkg::*;
#(
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
	parameter int TICK_BITS    = TICK_BITS_DEF,
	localparam int IW = $clog2(THREAD_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IW-1:0]        rd_idx,
	output slot_row_t            rd_row,
	output logic [TICK_BITS-1:0] rd_wake,
	output logic [TICK_BITS-1:0] rd_deadline,
	output logic [TICK_BITS-1:0] rd_nice,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_idx,
	input  slot_we_t             wr_we,
	input  slot_row_t            wr_row,
	input  logic [TICK_BITS-1:0] wr_wake,
	input  logic [TICK_BITS-1:0] wr_deadline,
	input  logic [TICK_BITS-1:0] wr_nice
);

	slot_row_t            row_q      [THREAD_SLOTS];
	logic [TICK_BITS-1:0] wake_q     [THREAD_SLOTS];
	logic [TICK_BITS-1:0] deadline_q [THREAD_SLOTS];
	logic [TICK_BITS-1:0] nice_q     [THREAD_SLOTS];

	assign rd_row      = row_q[rd_idx];
	assign rd_wake     = wake_q[rd_idx];
	assign rd_deadline = deadline_q[rd_idx];
	assign rd_nice     = nice_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				row_q[i]      <= '0;
				deadline_q[i] <= '0;
				nice_q[i]     <= '0;
			end
		end else if (wr_en) begin
			if (wr_we.used)     row_q[wr_idx].used    <= wr_row.used;
			if (wr_we.state)    row_q[wr_idx].state   <= wr_row.state;
			if (wr_we.channel)  row_q[wr_idx].channel <= wr_row.channel;
			if (wr_we.ref_id)   row_q[wr_idx].ref_id  <= wr_row.ref_id;
			if (wr_we.tag)      row_q[wr_idx].tag     <= wr_row.tag;
			if (wr_we.deadline) deadline_q[wr_idx]    <= wr_deadline;
			if (wr_we.nice)     nice_q[wr_idx]        <= wr_nice;
		end
	end

	// wake ticks are undefined until written
	always_ff @(posedge clk) begin
		if (wr_en && wr_we.wake) wake_q[wr_idx] <= wr_wake;
	end

endmodule

// ----- rtl/core/cooperative_thread_scheduler.sv -----
// Cooperative thread scheduler: slot table plus the command sequencer.
//
// One request at a time. Table commands (add, remove, set nice, unknown) run in
// F_EXEC and hand the result over from F_DONE. Notify walks the slots from 0,
// one per cycle, stopping at the first match unless notify_all. Yield and
// finish write the active slot, load the candidate, then examine one slot per
// cycle through the single table read port. in_stall is high while a request
// is in work; a finished result sits in the output register until taken.
module cooperative_thread_scheduler
	import cts_pkg::*;
#(
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
	parameter int TICK_BITS    = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [2:0]           thread_slot,
	input  logic [TICK_BITS-1:0] now,
	input  logic [TICK_BITS-1:0] delay_ticks,
	input  logic [1:0]           yield_kind,
	input  logic [TICK_BITS-1:0] wait_deadline,
	input  logic [7:0]           wait_channel,
	input  logic [15:0]          ref_id,
	input  logic                 notify_all,
	input  logic [31:0]          tag_value,
	input  logic [TICK_BITS-1:0] nice_ticks,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 next_valid,
	output logic [2:0]           next_slot,
	output logic                 next_timed_out,
	output logic [3:0]           notify_count,
	output logic [31:0]          resume_tag
);

	localparam int IW = $clog2(THREAD_SLOTS);
	localparam int KW = $clog2(THREAD_SLOTS + 1);
	localparam int TW = TICK_BITS;

	fsm_t state_q, state_d;

	// latched request
	cmd_t        cmd_q;
	logic [2:0]  slot_q;
	logic [TW-1:0] now_q, delay_q, dl_q, nice_q;
	logic [1:0]  kind_q;
	logic [7:0]  chan_q;
	logic [15:0] ref_q;
	logic        all_q;
	logic [31:0] tag_q;

	logic [IW-1:0] active_q, active_d;
	logic [IW-1:0] cand_q, cand_d;
	logic [TW-1:0] cand_wake_q, cand_wake_d;
	logic [IW-1:0] t_q, t_d;
	logic [KW-1:0] k_q, k_d;
	logic [KW-1:0] cnt_q, cnt_d;

	logic        res_valid_q, res_valid_d;
	logic [IW-1:0] res_slot_q, res_slot_d;
	logic        res_to_q, res_to_d;
	logic [KW-1:0] res_cnt_q, res_cnt_d;
	logic [31:0] res_tag_q, res_tag_d;

	logic        out_valid_q;

	// table ports
	logic [IW-1:0] rd_idx, wr_idx;
	slot_row_t     rd_row, wr_row;
	logic [TW-1:0] rd_wake, rd_deadline, rd_nice;
	logic [TW-1:0] wr_wake, wr_deadline, wr_nice;
	logic          wr_en;
	slot_we_t      wr_we;

	logic [IW-1:0] s_idx, t_next;
	logic          s_ok, live, wake_ge, dl_expired;
	thr_state_t    yst;

	cts_table #(.THREAD_SLOTS(THREAD_SLOTS), .TICK_BITS(TICK_BITS)) u_table (
		.clk, .arst_n,
		.rd_idx, .rd_row, .rd_wake, .rd_deadline, .rd_nice,
		.wr_en, .wr_idx, .wr_we, .wr_row, .wr_wake, .wr_deadline, .wr_nice
	);

	assign s_ok   = 32'(slot_q) < 32'(THREAD_SLOTS);
	assign s_idx  = IW'(slot_q);
	assign t_next = (32'(t_q) == THREAD_SLOTS - 1) ? '0 : t_q + IW'(1);
	assign yst    = thr_state_t'(3'(kind_q) + 3'd1);
	assign live   = rd_row.used && rd_row.state != ST_STOPPED;
	assign dl_expired = rd_deadline != '0 && rd_deadline < now_q;
	// shared compare: candidate wake against the examined slot
	assign wake_ge = (rd_row.state == ST_NOW ? now_q : cand_wake_q) >= rd_wake;

	assign in_stall = state_q != F_IDLE;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q  <= cmd_t'(cmd);
			slot_q <= thread_slot;
			now_q  <= TW'(now);
			delay_q <= TW'(delay_ticks);
			dl_q   <= TW'(wait_deadline);
			nice_q <= TW'(nice_ticks);
			kind_q <= yield_kind;
			chan_q <= wait_channel;
			ref_q  <= ref_id;
			all_q  <= notify_all;
			tag_q  <= tag_value;
		end
		cand_q      <= cand_d;
		cand_wake_q <= cand_wake_d;
		t_q         <= t_d;
		k_q         <= k_d;
		cnt_q       <= cnt_d;
		res_slot_q  <= res_slot_d;
		res_to_q    <= res_to_d;
		res_cnt_q   <= res_cnt_d;
		res_tag_q   <= res_tag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			active_q    <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			res_valid_q <= res_valid_d;
			if (state_q == F_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_DONE && (!out_valid_q || !out_stall)) begin
			next_valid     <= res_valid_q;
			next_slot      <= res_valid_q ? 3'(res_slot_q) : 3'd0;
			next_timed_out <= res_to_q;
			notify_count   <= 4'(res_cnt_q);
			resume_tag     <= res_tag_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		active_d    = active_q;
		cand_d      = cand_q;
		cand_wake_d = cand_wake_q;
		t_d         = t_q;
		k_d         = k_q;
		cnt_d       = cnt_q;
		res_valid_d = res_valid_q;
		res_slot_d  = res_slot_q;
		res_to_d    = res_to_q;
		res_cnt_d   = res_cnt_q;
		res_tag_d   = res_tag_q;
		rd_idx      = active_q;
		wr_en       = 1'b0;
		wr_idx      = active_q;
		wr_we       = '0;
		wr_row      = '0;
		wr_wake     = now_q;
		wr_deadline = '0;
		wr_nice     = '0;

		unique case (state_q)
			F_IDLE: begin
				if (in_valid) state_d = F_EXEC;
			end
			F_EXEC: begin
				res_valid_d = 1'b0;
				res_slot_d  = '0;
				res_to_d    = 1'b0;
				res_cnt_d   = '0;
				res_tag_d   = '0;
				state_d     = F_DONE;
				unique case (cmd_q)
					CMD_ADD: begin
						rd_idx = s_idx;
						wr_idx = s_idx;
						if (s_ok && !rd_row.used) begin
							wr_en  = 1'b1;
							wr_we  = '1;
							wr_row.used  = 1'b1;
							wr_row.state = ST_READY;
						end
					end
					CMD_REMOVE: begin
						wr_idx = s_idx;
						wr_en  = s_ok;
						wr_we.used  = 1'b1;
						wr_we.state = 1'b1;
						wr_row.state = ST_READY;
					end
					CMD_NICE: begin
						wr_idx  = s_idx;
						wr_en   = s_ok;
						wr_we.nice = 1'b1;
						wr_nice = nice_q;
					end
					CMD_NOTIFY: begin
						t_d     = '0;
						cnt_d   = '0;
						state_d = F_NOTIFY;
					end
					CMD_YIELD, CMD_FINISH: begin
						wr_en = rd_row.used;
						wr_we.state = 1'b1;
						state_d = F_CINIT;
						if (cmd_q == CMD_FINISH) begin
							wr_row.state = ST_STOPPED;
						end else begin
							wr_row.state = yst;
							wr_we.wake   = 1'b1;
							if (yst == ST_NOW)
								wr_wake = now_q;
							else if (delay_q == '0 && yst != ST_WAIT)
								wr_wake = now_q + rd_nice;
							else
								wr_wake = now_q + delay_q;
							if (yst == ST_WAIT) begin
								wr_we.deadline = 1'b1;
								wr_we.channel  = 1'b1;
								wr_we.ref_id   = 1'b1;
								wr_we.tag      = 1'b1;
								wr_deadline    = dl_q;
								wr_row.channel = chan_q;
								wr_row.ref_id  = ref_q;
								wr_row.tag     = tag_q;
							end
						end
					end
					default: ;
				endcase
			end
			F_CINIT: begin
				cand_d      = active_q;
				cand_wake_d = rd_wake;
				t_d         = (32'(active_q) == THREAD_SLOTS - 1) ? '0 : active_q + IW'(1);
				k_d         = KW'(1);
				state_d     = F_SCAN;
			end
			F_SCAN: begin
				rd_idx = t_q;
				wr_idx = t_q;
				t_d    = t_next;
				k_d    = k_q + KW'(1);
				if (32'(k_q) == THREAD_SLOTS) state_d = F_FINAL;
				if (live) begin
					case (rd_row.state)
						ST_READY: begin
							wr_en = 1'b1;
							wr_we.state  = 1'b1;
							wr_row.state = ST_RUNNING;
							res_valid_d  = 1'b1;
							res_slot_d   = t_q;
							res_tag_d    = rd_row.tag;
							active_d     = t_q;
							state_d      = F_DONE;
						end
						ST_NOW, ST_SLEEPING: begin
							if (rd_row.state == ST_NOW) begin
								// candidate's wake moves to now
								wr_en      = 1'b1;
								wr_idx     = cand_q;
								wr_we.wake = 1'b1;
								wr_wake    = now_q;
								cand_wake_d = now_q;
							end
							if (wake_ge) begin
								cand_d = t_q;
								if (t_q != cand_q) cand_wake_d = rd_wake;
							end
						end
						ST_WAIT: begin
							if (dl_expired) begin
								wr_en = 1'b1;
								wr_we.state  = 1'b1;
								wr_we.wake   = 1'b1;
								wr_row.state = ST_TIMEDOUT;
								wr_wake      = '0;
								res_valid_d  = 1'b1;
								res_slot_d   = t_q;
								res_to_d     = 1'b1;
								res_tag_d    = rd_row.tag;
								active_d     = t_q;
								state_d      = F_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			F_FINAL: begin
				rd_idx  = cand_q;
				wr_idx  = cand_q;
				state_d = F_DONE;
				if (live && !(rd_row.state == ST_WAIT && rd_deadline == '0)) begin
					wr_en = 1'b1;
					wr_we.state  = 1'b1;
					wr_row.state = rd_row.state == ST_WAIT ? ST_TIMEDOUT : ST_RUNNING;
					res_valid_d  = 1'b1;
					res_slot_d   = cand_q;
					res_to_d     = rd_row.state == ST_WAIT;
					res_tag_d    = rd_row.tag;
					active_d     = cand_q;
				end
			end
			F_NOTIFY: begin
				rd_idx = t_q;
				wr_idx = t_q;
				t_d    = t_next;
				if (32'(t_q) == THREAD_SLOTS - 1) state_d = F_DONE;
				if (rd_row.used && rd_row.state == ST_WAIT &&
				    rd_row.channel == chan_q && rd_row.ref_id == ref_q) begin
					wr_en = 1'b1;
					wr_we.state  = 1'b1;
					wr_we.wake   = 1'b1;
					wr_we.tag    = 1'b1;
					wr_we.ref_id = 1'b1;
					wr_row.state = ST_NOW;
					wr_row.tag   = tag_q;
					wr_wake      = now_q;
					cnt_d        = cnt_q + KW'(1);
					res_cnt_d    = cnt_q + KW'(1);
					if (!all_q) state_d = F_DONE;
				end
			end
			F_DONE: begin
				if (!out_valid_q || !out_stall) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

`ifndef SYNTH
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != F_IDLE |-> in_stall)
		else $error("request taken while busy");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !next_valid |-> next_slot == 3'd0 && !next_timed_out)
		else $error("no-thread result carries a slot");
	a_notify_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_valid |-> notify_count == 4'd0)
		else $error("schedule result carries a notify count");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_DONE && out_valid_q && out_stall |=> state_q == F_DONE)
		else $error("result dropped under stall");
`endif

endmodule

// ----- test/cts_checker.sv -----
// Request/result monitor with a slot-table predictor for the thread scheduler.
module cts_checker
	import cts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [2:0]  thread_slot,
	input  logic [31:0] now,
	input  logic [31:0] delay_ticks,
	input  logic [1:0]  yield_kind,
	input  logic [31:0] wait_deadline,
	input  logic [7:0]  wait_channel,
	input  logic [15:0] ref_id,
	input  logic        notify_all,
	input  logic [31:0] tag_value,
	input  logic [31:0] nice_ticks,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        next_valid,
	input  logic [2:0]  next_slot,
	input  logic        next_timed_out,
	input  logic [3:0]  notify_count,
	input  logic [31:0] resume_tag,
	output int          fail_count,
	output int          pending,
	output int          switch_count,
	output int          timeout_count
);

	localparam int NSLOT = THREAD_SLOTS_DEF;

	typedef struct packed {
		logic        chosen;
		logic [2:0]  slot;
		logic        timed_out;
		logic [3:0]  woken;
		logic [31:0] tag;
	} sched_result_t;

	logic        tbl_used [NSLOT];
	thr_state_t  tbl_state [NSLOT];
	logic [31:0] tbl_wake [NSLOT];
	logic [31:0] tbl_dl [NSLOT];
	logic [7:0]  tbl_chan [NSLOT];
	logic [15:0] tbl_ref [NSLOT];
	logic [31:0] tbl_tag [NSLOT];
	logic [31:0] tbl_nice [NSLOT];
	logic [2:0]  cur_slot;

	sched_result_t result_q[$];

	assign pending = result_q.size();

	function automatic int choose_next(logic [31:0] t_now);
		logic [2:0] c;
		logic [2:0] t;
		c = cur_slot;
		for (int k = 1; k <= NSLOT; k++) begin
			t = cur_slot + 3'(k);
			if (!tbl_used[t] || tbl_state[t] == ST_STOPPED)
				continue;
			case (tbl_state[t])
				ST_READY: begin
					tbl_state[t] = ST_RUNNING;
					return t;
				end
				ST_NOW: begin
					tbl_wake[c] = t_now;
					if (tbl_wake[c] >= tbl_wake[t])
						c = t;
				end
				ST_SLEEPING: begin
					if (tbl_wake[c] >= tbl_wake[t])
						c = t;
				end
				ST_WAIT: begin
					if (tbl_dl[t] != 0 && tbl_dl[t] < t_now) begin
						tbl_state[t] = ST_TIMEDOUT;
						tbl_wake[t] = '0;
						return t;
					end
				end
				default: ;
			endcase
		end
		if (!tbl_used[c] || tbl_state[c] == ST_STOPPED)
			return -1;
		if (tbl_state[c] == ST_WAIT) begin
			if (tbl_dl[c] == 0)
				return -1;
			tbl_state[c] = ST_TIMEDOUT;
		end else begin
			tbl_state[c] = ST_RUNNING;
		end
		return c;
	endfunction

	function automatic sched_result_t apply_request();
		sched_result_t r;
		thr_state_t ns;
		int pick;
		logic [2:0] s;
		r = '0;
		s = thread_slot;
		case (cmd)
			CMD_ADD: begin
				if (!tbl_used[s]) begin
					tbl_used[s] = 1'b1;
					tbl_state[s] = ST_READY;
					tbl_wake[s] = now;
					tbl_dl[s] = '0;
					tbl_chan[s] = '0;
					tbl_ref[s] = '0;
					tbl_tag[s] = '0;
					tbl_nice[s] = '0;
				end
			end
			CMD_REMOVE: begin
				tbl_used[s] = 1'b0;
				tbl_state[s] = ST_READY;
			end
			CMD_YIELD, CMD_FINISH: begin
				if (tbl_used[cur_slot]) begin
					if (cmd == CMD_FINISH) begin
						tbl_state[cur_slot] = ST_STOPPED;
					end else begin
						ns = thr_state_t'({1'b0, yield_kind} + 3'd1);
						if (ns == ST_NOW)
							tbl_wake[cur_slot] = now;
						else if (delay_ticks == 0 && ns != ST_WAIT)
							tbl_wake[cur_slot] = now + tbl_nice[cur_slot];
						else
							tbl_wake[cur_slot] = now + delay_ticks;
						if (ns == ST_WAIT) begin
							tbl_dl[cur_slot] = wait_deadline;
							tbl_chan[cur_slot] = wait_channel;
							tbl_ref[cur_slot] = ref_id;
							tbl_tag[cur_slot] = tag_value;
						end
						tbl_state[cur_slot] = ns;
					end
				end
				pick = choose_next(now);
				if (pick >= 0) begin
					cur_slot = 3'(pick);
					r.chosen = 1'b1;
					r.slot = 3'(pick);
					r.timed_out = tbl_state[pick] == ST_TIMEDOUT;
					r.tag = tbl_tag[pick];
				end
			end
			CMD_NOTIFY: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_used[i] && tbl_state[i] == ST_WAIT &&
					    tbl_chan[i] == wait_channel && tbl_ref[i] == ref_id) begin
						tbl_state[i] = ST_NOW;
						tbl_wake[i] = now;
						tbl_tag[i] = tag_value;
						tbl_ref[i] = '0;
						r.woken = r.woken + 4'd1;
						if (!notify_all)
							break;
					end
				end
			end
			CMD_NICE: tbl_nice[s] = nice_ticks;
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t e;
		sched_result_t a;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				tbl_used[i] = 1'b0;
				tbl_state[i] = ST_READY;
				tbl_wake[i] = '0;
				tbl_dl[i] = '0;
				tbl_chan[i] = '0;
				tbl_ref[i] = '0;
				tbl_tag[i] = '0;
				tbl_nice[i] = '0;
			end
			cur_slot = '0;
			result_q.delete();
			fail_count <= 0;
			switch_count <= 0;
			timeout_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				a = '{next_valid, next_slot, next_timed_out, notify_count, resume_tag};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, a);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (e !== a) begin
						$display("%0t: mismatch exp valid=%b slot=%0d to=%b cnt=%0d tag=%h",
						         $time, e.chosen, e.slot, e.timed_out, e.woken, e.tag);
						$display("%0t:          got valid=%b slot=%0d to=%b cnt=%0d tag=%h",
						         $time, a.chosen, a.slot, a.timed_out, a.woken, a.tag);
						fail_count <= fail_count + 1;
					end
					if (e.chosen)
						switch_count <= switch_count + 1;
					if (e.timed_out)
						timeout_count <= timeout_count + 1;
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(apply_request());
		end
	end

endmodule

// ----- test/tb_top.sv -----
// Stimulus, clock/reset and verdict for the cooperative thread scheduler.
module tb_top;
	import cts_pkg::*;

	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;
	localparam logic [1:0] YK_RUN   = 2'd0;
	localparam logic [1:0] YK_SLEEP = 2'd1;
	localparam logic [1:0] YK_NOW   = 2'd2;
	localparam logic [1:0] YK_WAIT  = 2'd3;
	localparam int NUM_RANDOM = 1800;
	localparam int CYCLE_LIMIT = 500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [2:0]  thread_slot = '0;
	logic [31:0] now = '0;
	logic [31:0] delay_ticks = '0;
	logic [1:0]  yield_kind = '0;
	logic [31:0] wait_deadline = '0;
	logic [7:0]  wait_channel = '0;
	logic [15:0] ref_id = '0;
	logic        notify_all = 1'b0;
	logic [31:0] tag_value = '0;
	logic [31:0] nice_ticks = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        next_valid;
	logic [2:0]  next_slot;
	logic        next_timed_out;
	logic [3:0]  notify_count;
	logic [31:0] resume_tag;

	int fail_count, pending, switch_count, timeout_count;
	int cycles = 0;
	int sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	logic [31:0] tick = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cooperative_thread_scheduler u_top (.*);

	cts_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver back-pressure: random modes held for random stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3);
			stall_left = $urandom_range(5, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(3) == 0);
			2: out_stall <= $urandom_range(1);
			default: out_stall <= ($urandom_range(3) != 0);
		endcase
	end

	task automatic send_request(logic [2:0] c, logic [2:0] s, logic [31:0] t_now,
	                            logic [31:0] dly, logic [1:0] kind, logic [31:0] dl,
	                            logic [7:0] ch, logic [15:0] rid, logic all,
	                            logic [31:0] tg, logic [31:0] nc);
		cmd <= c;
		thread_slot <= s;
		now <= t_now;
		delay_ticks <= dly;
		yield_kind <= kind;
		wait_deadline <= dl;
		wait_channel <= ch;
		ref_id <= rid;
		notify_all <= all;
		tag_value <= tg;
		nice_ticks <= nc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		// burst/gap pacing on the sender side
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic send_random();
		int p;
		logic [2:0] c;
		logic [31:0] dly, dl, nc;
		logic [7:0] ch;
		logic [15:0] rid;
		p = $urandom_range(99);
		if (p < 15) c = CMD_ADD;
		else if (p < 22) c = CMD_REMOVE;
		else if (p < 52) c = CMD_YIELD;
		else if (p < 58) c = CMD_FINISH;
		else if (p < 80) c = CMD_NOTIFY;
		else if (p < 92) c = CMD_NICE;
		else if (p < 96) c = CMD_RSVD_A;
		else c = CMD_RSVD_B;
		if ($urandom_range(49) == 0)
			tick = $urandom;
		else
			tick = tick + $urandom_range(0, 20);
		p = $urandom_range(9);
		dly = (p < 7) ? $urandom_range(0, 30) : (p < 8) ? 32'd0 : $urandom;
		p = $urandom_range(9);
		dl = (p < 3) ? 32'd0 : (p < 8) ? tick + $urandom_range(0, 40) - 10 : $urandom;
		ch = ($urandom_range(6) != 0) ? 8'($urandom_range(2)) : 8'($urandom);
		rid = ($urandom_range(6) != 0) ? 16'($urandom_range(2)) : 16'($urandom);
		nc = ($urandom_range(9) < 7) ? $urandom_range(0, 40) : $urandom;
		send_request(c, 3'($urandom_range(7)), tick, dly, 2'($urandom_range(3)), dl,
		             ch, rid, 1'($urandom_range(1)), $urandom, nc);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// slot 0 first so the initial active slot's wake tick is defined
		send_request(CMD_ADD, 3'd0, 32'd100, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_ADD, 3'd7, 32'd101, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_ADD, 3'd3, 32'd102, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_ADD, 3'd3, 32'hffff_ffff, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_NICE, 3'd3, '0, '0, YK_RUN, '0, '0, '0, 1'b0, '0, 32'hffff_ffff);
		send_request(CMD_NICE, 3'd5, '0, '0, YK_RUN, '0, '0, '0, 1'b0, '0, 32'd7);
		send_request(CMD_YIELD, '0, 32'd110, '0, YK_SLEEP, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_YIELD, '0, 32'd111, 32'hffff_ffff, YK_RUN, '0, '0, '0, 1'b0,
		             '0, '0);
		send_request(CMD_YIELD, '0, 32'd112, '0, YK_NOW, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_YIELD, '0, 32'd113, 32'd5, YK_WAIT, 32'd0, 8'hff, 16'hffff,
		             1'b0, 32'hdead_beef, '0);
		send_request(CMD_YIELD, '0, 32'd114, '0, YK_WAIT, 32'd0, 8'hff, 16'hffff, 1'b0,
		             32'h1234_5678, '0);
		send_request(CMD_NOTIFY, '0, 32'd115, '0, YK_RUN, '0, 8'hff, 16'hffff, 1'b0,
		             32'hffff_ffff, '0);
		send_request(CMD_NOTIFY, '0, 32'd116, '0, YK_RUN, '0, 8'hff, 16'hffff, 1'b1,
		             32'h5555_aaaa, '0);
		send_request(CMD_YIELD, '0, 32'd117, '0, YK_WAIT, 32'd118, 8'd1, 16'd1, 1'b0,
		             32'h0f0f_0f0f, '0);
		send_request(CMD_YIELD, '0, 32'd200, '0, YK_WAIT, 32'hffff_ffff, 8'd2, 16'd2,
		             1'b0, '0, '0);
		send_request(CMD_FINISH, '0, 32'd201, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_REMOVE, 3'd7, 32'd202, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		send_request(CMD_RSVD_A, 3'd7, 32'hffff_ffff, 32'hffff_ffff, YK_WAIT,
		             32'hffff_ffff, 8'hff, 16'hffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_RSVD_B, '0, '0, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		// finish everything left so the scheduler runs dry
		repeat (4)
			send_request(CMD_FINISH, '0, 32'd300, '0, YK_RUN, '0, '0, '0, 1'b0, '0, '0);
		tick = 32'd400;
		repeat (NUM_RANDOM)
			send_random();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		$display("Sent %0d requests; %0d thread switches, %0d wait timeouts seen.",
		         sent, switch_count, timeout_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/cts_pkg.sv
rtl/core/cts_table.sv
rtl/core/cooperative_thread_scheduler.sv
test/cts_checker.sv
test/tb_top.sv
